// ===== hw/rtl/clpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, pattern codes and sizes for the cache line pattern compressor.
// No dependencies.
package clpc_pkg;

    localparam int LINE_WORDS = 16;
    localparam int DICT_DEPTH = 16;
    localparam int IDX_W      = $clog2(DICT_DEPTH);
    localparam int WC_W       = $clog2(LINE_WORDS);
    localparam int WORD_W     = 32;
    localparam int CODE_W     = 34;
    localparam int LEN_W      = 6;
    localparam int PAT_W      = 3;
    localparam int BITS_W     = 10;
    localparam int MDATA_W    = 56;

    localparam logic [PAT_W-1:0] PAT_ZZZZ = 3'd0;
    localparam logic [PAT_W-1:0] PAT_ZZZX = 3'd1;
    localparam logic [PAT_W-1:0] PAT_MMMM = 3'd2;
    localparam logic [PAT_W-1:0] PAT_MMMX = 3'd3;
    localparam logic [PAT_W-1:0] PAT_MMXX = 3'd4;
    localparam logic [PAT_W-1:0] PAT_XXXX = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              done;
        logic [PAT_W-1:0]  pat;
        logic [IDX_W-1:0]  idx;
    } token_t;

endpackage

// ===== hw/rtl/clpc_cell.sv =====
`timescale 1ns / 1ps
// One dictionary cell: holds one entry, compares the passing item against it
// and appends the item when the cell is the first free one. Uses clpc_pkg.
module clpc_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic [clpc_pkg::IDX_W-1:0] cell_index,
    input  clpc_pkg::token_t           tok_in,
    output clpc_pkg::token_t           tok_out,
    output logic                       entry_valid
);
    import clpc_pkg::*;

    logic [WORD_W-1:0] entry_reg;
    logic              ev_reg;
    logic              ev_next;
    logic              wr_entry;
    token_t            tok_reg;
    token_t            tok_next;
    logic              hi_eq;
    logic              mid_eq;
    logic              lo_eq;

    assign hi_eq  = entry_reg[31:16] == tok_in.word[31:16];
    assign mid_eq = entry_reg[15:8]  == tok_in.word[15:8];
    assign lo_eq  = entry_reg[7:0]   == tok_in.word[7:0];

    always_comb begin
        tok_next = tok_in;
        ev_next  = ev_reg;
        wr_entry = 1'b0;
        if (tok_in.valid && !tok_in.done) begin
            if (ev_reg) begin
                if (hi_eq) begin
                    tok_next.done = 1'b1;
                    tok_next.idx  = cell_index;
                    if (mid_eq) begin
                        tok_next.pat = lo_eq ? PAT_MMMM : PAT_MMMX;
                    end else begin
                        tok_next.pat = PAT_MMXX;
                    end
                end
            end else begin
                wr_entry      = 1'b1;
                ev_next       = 1'b1;
                tok_next.done = 1'b1;
                tok_next.pat  = PAT_XXXX;
            end
        end
        if (tok_in.valid && tok_in.last) begin
            ev_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            ev_reg  <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_next;
            ev_reg  <= ev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_entry) begin
                entry_reg <= tok_in.word;
            end
        end
    end

    assign tok_out     = tok_reg;
    assign entry_valid = ev_reg;

endmodule

// ===== hw/rtl/clpc_encode.sv =====
`timescale 1ns / 1ps
// Code builder: forms the right-aligned code and its length from a resolved
// item at the end of the cell chain. Uses clpc_pkg.
module clpc_encode (
    input  clpc_pkg::token_t            tok,
    output logic [clpc_pkg::CODE_W-1:0] code_bits,
    output logic [clpc_pkg::LEN_W-1:0]  code_length,
    output logic [clpc_pkg::PAT_W-1:0]  pattern
);
    import clpc_pkg::*;

    always_comb begin
        pattern = tok.done ? tok.pat : PAT_XXXX;
        case (pattern)
            PAT_ZZZZ: begin
                code_bits   = '0;
                code_length = 6'd2;
            end
            PAT_ZZZX: begin
                code_bits   = CODE_W'({4'hD, tok.word[7:0]});
                code_length = 6'd12;
            end
            PAT_MMMM: begin
                code_bits   = CODE_W'({2'b10, tok.idx});
                code_length = 6'd6;
            end
            PAT_MMMX: begin
                code_bits   = CODE_W'({4'hE, tok.idx, tok.word[7:0]});
                code_length = 6'd16;
            end
            PAT_MMXX: begin
                code_bits   = CODE_W'({4'hC, tok.idx, tok.word[15:0]});
                code_length = 6'd24;
            end
            default: begin
                code_bits   = {2'b01, tok.word};
                code_length = 6'd34;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cache_line_pattern_compressor_unit.sv =====
`timescale 1ns / 1ps
// Cache line pattern compressor top level: input stage, chain of dictionary
// cells, code builder and output skid stage. Uses clpc_pkg, clpc_cell, clpc_encode.
//
// Feed a cache line as 16 successive 32-bit words on s_tdata (first byte in
// bits 31:24). Each word gives one result on the m_ channel: the code,
// right-aligned, its length and the running bit count of the line in m_tdata,
// the pattern kind in m_tuser, and m_tlast on the last word of the line.
// The dictionary lives in a row of 16 cells; each item walks the row one cell
// per cycle while the row is not held, so it sees every entry left by the
// items ahead of it. Throughput: one item per cycle while s_tready is high.
// Each item passes the 16 cell registers, then the output register that drives
// m_tvalid. A two-entry output stage takes the item that arrives while a result
// waits with m_tready low; once that item sits in the skid entry, s_tready
// falls and the whole row holds.
// The dictionary, word count and bit count clear behind the last word of each
// line. Reset empties the pipeline, the dictionary and the counters; the first
// word after reset starts a new line.
module cache_line_pattern_compressor_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [clpc_pkg::WORD_W-1:0]  s_tdata,   // word[31:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [clpc_pkg::MDATA_W-1:0] m_tdata,   // code_bits[33:0], code_length[39:34],
                                                    // line_bits[49:40], zeros[55:50]
    output logic [clpc_pkg::PAT_W-1:0]   m_tuser,   // pattern[2:0]
    output logic                         m_tlast
);
    import clpc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [PAT_W-1:0]  pattern;
        logic              line_end;
        logic [BITS_W-1:0] line_bits;
    } result_t;

    logic                  en;
    token_t                tok [DICT_DEPTH+1];
    logic [DICT_DEPTH-1:0] entry_valid;
    logic [WC_W-1:0]       wcount_reg;
    logic [WC_W-1:0]       wcount_next;
    logic [BITS_W-1:0]     btotal_reg;
    logic [BITS_W-1:0]     btotal_next;
    logic [BITS_W-1:0]     line_bits;
    logic [CODE_W-1:0]     enc_code;
    logic [LEN_W-1:0]      enc_len;
    logic [PAT_W-1:0]      enc_pat;
    logic                  s_last;
    logic                  arrive;
    result_t               res;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign s_last   = wcount_reg == WC_W'(LINE_WORDS - 1);

    always_comb begin
        tok[0].valid = s_tvalid && s_tready;
        tok[0].word  = s_tdata;
        tok[0].last  = s_last;
        tok[0].done  = s_tdata[31:8] == '0;
        tok[0].pat   = (s_tdata == '0) ? PAT_ZZZZ : PAT_ZZZX;
        tok[0].idx   = '0;
    end

    assign wcount_next = s_last ? '0 : wcount_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcount_reg <= '0;
        end else if (s_tvalid && s_tready) begin
            wcount_reg <= wcount_next;
        end
    end

    for (genvar j = 0; j < DICT_DEPTH; j++) begin : g_cell
        clpc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .cell_index  (IDX_W'(j)),
            .tok_in      (tok[j]),
            .tok_out     (tok[j+1]),
            .entry_valid (entry_valid[j])
        );
    end

    clpc_encode u_encode (
        .tok         (tok[DICT_DEPTH]),
        .code_bits   (enc_code),
        .code_length (enc_len),
        .pattern     (enc_pat)
    );

    assign arrive      = en && tok[DICT_DEPTH].valid;
    assign line_bits   = btotal_reg + BITS_W'(enc_len);
    assign btotal_next = tok[DICT_DEPTH].last ? '0 : line_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btotal_reg <= '0;
        end else if (arrive) begin
            btotal_reg <= btotal_next;
        end
    end

    always_comb begin
        res.code_bits   = enc_code;
        res.code_length = enc_len;
        res.pattern     = enc_pat;
        res.line_end    = tok[DICT_DEPTH].last;
        res.line_bits   = line_bits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= arrive;
            end
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (arrive) begin
                out_reg <= res;
            end
        end else if (arrive) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.line_bits, out_reg.code_length, out_reg.code_bits};
    assign m_tuser  = out_reg.pattern;
    assign m_tlast  = out_reg.line_end;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_dict_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(entry_valid))
        else $error("dictionary entries changed while the cell row was held");

    a_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == PAT_ZZZZ) |-> (out_reg.code_length == 6'd2))
        else $error("zero word not coded with two bits");

endmodule

// ===== bench/cache_line_pattern_compressor_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cache_line_pattern_compressor_unit: streams cache lines
// word by word and checks every code against a built-in line compressor.
// Depends on clpc_pkg and the compressor RTL.
module cache_line_pattern_compressor_unit_tb;
    import clpc_pkg::*;

    localparam logic [3:0] PFX_ZZZX = 4'b1101;
    localparam logic [1:0] PFX_MMMM = 2'b10;
    localparam logic [3:0] PFX_MMMX = 4'b1110;
    localparam logic [3:0] PFX_MMXX = 4'b1100;
    localparam logic [1:0] PFX_XXXX = 2'b01;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [PAT_W-1:0]  pat;
        logic              line_end;
        logic [BITS_W-1:0] line_bits;
    } code_rec_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                drain_first;
    } feed_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [MDATA_W-1:0]  m_tdata;
    logic [PAT_W-1:0]    m_tuser;
    logic                m_tlast;

    feed_t               word_feed[$];
    code_rec_t           code_expect[$];
    logic [WORD_W-1:0]   dict_words[DICT_DEPTH];
    int                  dict_fill;
    int                  word_pos;
    logic [BITS_W-1:0]   line_total;
    bit                  in_taken;
    int                  words_taken;
    int                  errors;

    cache_line_pattern_compressor_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic code_rec_t compress_word(logic [WORD_W-1:0] w);
        code_rec_t         r;
        int                hit;
        logic [IDX_W-1:0]  idx;
        r = '0;
        hit = -1;
        if (w[31:8] == '0) begin
            if (w == '0) begin
                r.len = 6'd2;
                r.pat = PAT_ZZZZ;
            end else begin
                r.code = {PFX_ZZZX, w[7:0]};
                r.len  = 6'd12;
                r.pat  = PAT_ZZZX;
            end
        end else begin
            for (int j = 0; j < dict_fill; j++)
                if (hit < 0 && dict_words[j][31:16] == w[31:16])
                    hit = j;
            idx = hit[IDX_W-1:0];
            if (hit < 0) begin
                r.code = {PFX_XXXX, w};
                r.len  = 6'd34;
                r.pat  = PAT_XXXX;
                if (dict_fill < DICT_DEPTH) begin
                    dict_words[dict_fill] = w;
                    dict_fill++;
                end
            end else if (dict_words[hit] == w) begin
                r.code = {PFX_MMMM, idx};
                r.len  = 6'd6;
                r.pat  = PAT_MMMM;
            end else if (dict_words[hit][31:8] == w[31:8]) begin
                r.code = {PFX_MMMX, idx, w[7:0]};
                r.len  = 6'd16;
                r.pat  = PAT_MMMX;
            end else begin
                r.code = {PFX_MMXX, idx, w[15:0]};
                r.len  = 6'd24;
                r.pat  = PAT_MMXX;
            end
        end
        line_total  = line_total + BITS_W'(r.len);
        r.line_bits = line_total;
        r.line_end  = (word_pos == LINE_WORDS - 1);
        if (r.line_end) begin
            dict_fill  = 0;
            word_pos   = 0;
            line_total = '0;
        end else begin
            word_pos++;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic queue_word(logic [WORD_W-1:0] w, bit drain_first);
        feed_t f;
        f.word        = w;
        f.drain_first = drain_first;
        word_feed.push_back(f);
    endtask

    function automatic bit calm_stretch();
        return words_taken >= 150 && words_taken < 270;
    endfunction

    // predict on accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                code_expect.push_back(compress_word(s_tdata));
                words_taken++;
            end
        end
    end

    // driver: advance on accept, idle at random, drain before marked items
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (word_feed.size() != 0 &&
                    (!word_feed[0].drain_first || code_expect.size() == 0) &&
                    (calm_stretch() || $urandom_range(99) >= 14)) begin
                    s_tdata  <= word_feed[0].word;
                    s_tvalid <= 1'b1;
                    word_feed[0].drain_first = 1'b0;
                    void'(word_feed.pop_front());
                end else begin
                    s_tdata  <= $urandom;
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm_stretch() || $urandom_range(99) >= 14;
        end
    end

    // monitor
    always @(posedge aclk) begin : result_check
        code_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (code_expect.size() == 0) begin
                flag_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            end else begin
                want = code_expect.pop_front();
                if (m_tdata[33:0] !== want.code)
                    flag_mismatch("code_bits", 64'(m_tdata[33:0]), 64'(want.code));
                if (m_tdata[39:34] !== want.len)
                    flag_mismatch("code_length", 64'(m_tdata[39:34]), 64'(want.len));
                if (m_tdata[49:40] !== want.line_bits)
                    flag_mismatch("line_bits", 64'(m_tdata[49:40]),
                                  64'(want.line_bits));
                if (m_tuser !== want.pat)
                    flag_mismatch("pattern", 64'(m_tuser), 64'(want.pat));
                if (m_tlast !== want.line_end)
                    flag_mismatch("line_end", 64'(m_tlast), 64'(want.line_end));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] line_words[$];
        logic [WORD_W-1:0] w;
        logic [15:0]       base;
        int                kind;
        int                total;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        dict_fill   = 0;
        word_pos    = 0;
        line_total  = '0;
        words_taken = 0;
        errors      = 0;

        // one directed line: zero, low byte only, all match kinds
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'h0000_00FF, 1'b0);
        queue_word(32'h0000_0001, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h0000_0100, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'hFFFF_FF00, 1'b0);
        queue_word(32'hFFFF_0000, 1'b0);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'h1234_AB00, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h1234_5699, 1'b0);
        queue_word(32'h0000_0100, 1'b0);
        queue_word(32'h8000_0001, 1'b0);
        queue_word(32'hFFFF_5678, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0);

        total = 0;
        while (total < 448) begin
            line_words.delete();
            if ($urandom_range(9) == 0) begin
                // fill the dictionary with 15 entries, then hit one of them
                base = $urandom;
                for (int k = 0; k < LINE_WORDS - 1; k++) begin
                    w = $urandom;
                    w[31:16] = {1'b1, 15'(base + 16'(k))};
                    line_words.push_back(w);
                end
                line_words.push_back(line_words[$urandom_range(LINE_WORDS - 2)]);
            end else begin
                for (int k = 0; k < LINE_WORDS; k++) begin
                    kind = $urandom_range(99);
                    w = $urandom;
                    if (kind < 10)
                        w = '0;
                    else if (kind < 20)
                        w = WORD_W'($urandom_range(255));
                    else if (line_words.size() != 0 && kind < 40)
                        w = line_words[$urandom_range(line_words.size() - 1)];
                    else if (line_words.size() != 0 && kind < 55)
                        w = {line_words[$urandom_range(line_words.size() - 1)][31:8],
                             w[7:0]};
                    else if (line_words.size() != 0 && kind < 70)
                        w = {line_words[$urandom_range(line_words.size() - 1)][31:16],
                             w[15:0]};
                    line_words.push_back(w);
                end
            end
            foreach (line_words[k]) begin
                queue_word(line_words[k],
                           total == 100 || total == 237 || total == 420);
                total++;
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (word_feed.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (code_expect.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/clpc_pkg.sv
hw/rtl/clpc_cell.sv
hw/rtl/clpc_encode.sv
hw/rtl/cache_line_pattern_compressor_unit.sv
bench/cache_line_pattern_compressor_unit_tb.sv
